### hw/rtl/ctrspn_pkg.sv
// Shared types, codes and helper functions of the counter-mode SPN decrypt unit.
package ctrspn_pkg;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_DECRYPT = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY  = 2'd0;
    localparam logic [1:0] CFG_PERM = 2'd1;
    localparam logic [1:0] CFG_CTRH = 2'd2;

    localparam logic [7:0]  KEY_CONST_A = 8'h80;
    localparam logic [7:0]  KEY_CONST_B = 8'h30;
    localparam logic [23:0] PERM_RESET  = 24'd16041608;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  sbox_index;
        logic [7:0]  sbox_value;
        logic [15:0] cipher_block;
    } t_in_item;

    typedef struct packed {
        logic [15:0] plain_block;
        logic [15:0] counter_used;
    } t_out_item;

    // Everything an item carries from one cell to the next.
    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic [7:0]  sbox_index;
        logic [7:0]  sbox_value;
        logic [15:0] cipher_block;
        logic [15:0] ctr;
        logic [15:0] m;
        logic [7:0]  w2;
        logic [7:0]  w3;
        logic [7:0]  w4;
        logic [7:0]  w5;
    } t_cell_bus;

    // Exchange the two nibbles of a byte.
    function automatic logic [7:0] nib_swap(input logic [7:0] b);
        return {b[3:0], b[7:4]};
    endfunction

    // Output bit 7-i takes input bit 7-entry i of the map.
    function automatic logic [7:0] bit_perm(input logic [7:0] s, input logic [23:0] pm);
        logic [7:0] r;
        logic [2:0] src;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            src = pm[3*i +: 3];
            r[7-i] = s[3'd7 - src];
        end
        return r;
    endfunction

endpackage

### hw/rtl/ctrspn_cell.sv
// One cell of the chain: a private S-box copy with two registered read ports.
module ctrspn_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  ctrspn_pkg::t_cell_bus i_bus,
    input  logic [7:0]            i_addr_a,
    input  logic [7:0]            i_addr_b,
    output ctrspn_pkg::t_cell_bus o_bus,
    output logic [7:0]            o_data_a,
    output logic [7:0]            o_data_b
);
    import ctrspn_pkg::*;

    logic [7:0]   r_mem [256];
    logic [255:0] r_vld;
    t_cell_bus    r_bus;
    logic [7:0]   r_data_a;
    logic [7:0]   r_data_b;
    logic         w_load;

    // A load item updates this copy as it passes, so older items ahead keep their table.
    assign w_load = i_en && i_bus.valid && (i_bus.op == OP_LOAD);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[i_bus.sbox_index] <= i_bus.sbox_value;
        end
    end

    // Entry valid bits; an entry never loaded reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_load) begin
            r_vld[i_bus.sbox_index] <= 1'b1;
        end
    end

    // Registered reads travel alongside the item.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= r_vld[i_addr_a] ? r_mem[i_addr_a] : 8'd0;
            r_data_b <= r_vld[i_addr_b] ? r_mem[i_addr_b] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus <= '0;
        end else if (i_en) begin
            r_bus <= i_bus;
        end
    end

    assign o_bus    = r_bus;
    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

### hw/rtl/ctr_mode_spn_block_decrypt_unit.sv
// Top level of the counter-mode SPN decrypt unit: a chain of five S-box cells.
//
// Input channel: i_in_valid, o_in_stall and i_in_item. An item is taken at a
// clock edge with valid high and stall low. A load item writes one S-box
// entry, a restart item clears the counter low byte, a decrypt item gives one
// result, and the unused code does nothing.
// Output channel: o_out_valid, i_out_stall and o_out_item, carrying the
// plaintext block and the counter block that was encrypted.
// Configuration: i_cfg_valid, o_cfg_ready (always high), i_cfg_index and
// i_cfg_data; write only while no item is in flight.
// Path: a decrypt item taken at one edge is captured by cell 0 at the taking
// edge, then passes through cells 1 to 4 and the output register in that order
// before it appears at the output.
// Throughput: one item per cycle while the receiver does not stall a result;
// each cell holds its own S-box copy read at two addresses.
// When the receiver stalls a waiting result, the whole chain holds and
// o_in_stall rises until the result is taken.
// Reset clears the S-box valid bits of every cell, the counter low byte and
// the registers to their reset values; the block takes items at once.
module ctr_mode_spn_block_decrypt_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ctrspn_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ctrspn_pkg::t_out_item o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [23:0]           i_cfg_data
);
    import ctrspn_pkg::*;

    logic [15:0] r_key;
    logic [23:0] r_perm;
    logic [7:0]  r_ctr_high;
    logic [7:0]  r_ctr_low;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic        w_en;
    logic        w_acc;

    t_cell_bus   w_bus_in  [5];
    t_cell_bus   w_bus_out [5];
    logic [7:0]  w_addr_a  [5];
    logic [7:0]  w_addr_b  [5];
    logic [7:0]  w_data_a  [5];
    logic [7:0]  w_data_b  [5];
    logic [15:0] w_last_m;

    // The chain moves unless a finished result is held by the receiver.
    assign w_en        = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign w_acc       = i_in_valid && w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= '0;
            r_perm     <= PERM_RESET;
            r_ctr_high <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY:  r_key      <= i_cfg_data[15:0];
                CFG_PERM: r_perm     <= i_cfg_data;
                CFG_CTRH: r_ctr_high <= i_cfg_data[7:0];
                default:  ;
            endcase
        end
    end

    // Counter low byte steps on each accepted decrypt item and clears on an accepted restart item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr_low <= '0;
        end else if (w_acc) begin
            case (i_in_item.op)
                OP_DECRYPT: r_ctr_low <= r_ctr_low + 8'd1;
                OP_RESTART: r_ctr_low <= '0;
                default:    ;
            endcase
        end
    end

    // Cell 0 looks up S[swap(w1)] for the second round key.
    always_comb begin
        w_bus_in[0]              = '0;
        w_bus_in[0].valid        = w_acc;
        w_bus_in[0].op           = i_in_item.op;
        w_bus_in[0].sbox_index   = i_in_item.sbox_index;
        w_bus_in[0].sbox_value   = i_in_item.sbox_value;
        w_bus_in[0].cipher_block = i_in_item.cipher_block;
        w_bus_in[0].ctr          = {r_ctr_high, r_ctr_low};
        w_addr_a[0]              = nib_swap(r_key[7:0]);
        w_addr_b[0]              = nib_swap(r_key[7:0]);
    end

    // Cell 1 finishes w2 and w3 and looks up S[swap(w3)].
    always_comb begin
        w_bus_in[1]    = w_bus_out[0];
        w_bus_in[1].w2 = r_key[15:8] ^ KEY_CONST_A ^ w_data_a[0];
        w_bus_in[1].w3 = w_bus_in[1].w2 ^ r_key[7:0];
        w_addr_a[1]    = nib_swap(w_bus_in[1].w3);
        w_addr_b[1]    = nib_swap(w_bus_in[1].w3);
    end

    // Cell 2 finishes w4 and w5 and is the first round: counter XOR the key itself.
    always_comb begin
        w_bus_in[2]    = w_bus_out[1];
        w_bus_in[2].w4 = w_bus_out[1].w2 ^ KEY_CONST_B ^ w_data_a[1];
        w_bus_in[2].w5 = w_bus_in[2].w4 ^ w_bus_out[1].w3;
        w_bus_in[2].m  = w_bus_out[1].ctr ^ r_key;
        w_addr_a[2]    = w_bus_in[2].m[15:8];
        w_addr_b[2]    = w_bus_in[2].m[7:0];
    end

    // Cells 3 and 4 are the later rounds with keys w2:w3 and w4:w5.
    always_comb begin
        w_bus_in[3]   = w_bus_out[2];
        w_bus_in[3].m = {bit_perm(w_data_a[2], r_perm), bit_perm(w_data_b[2], r_perm)}
                        ^ {w_bus_out[2].w2, w_bus_out[2].w3};
        w_addr_a[3]   = w_bus_in[3].m[15:8];
        w_addr_b[3]   = w_bus_in[3].m[7:0];

        w_bus_in[4]   = w_bus_out[3];
        w_bus_in[4].m = {bit_perm(w_data_a[3], r_perm), bit_perm(w_data_b[3], r_perm)}
                        ^ {w_bus_out[3].w4, w_bus_out[3].w5};
        w_addr_a[4]   = w_bus_in[4].m[15:8];
        w_addr_b[4]   = w_bus_in[4].m[7:0];
    end

    for (genvar g = 0; g < 5; g++) begin : g_cell
        ctrspn_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_bus    (w_bus_in[g]),
            .i_addr_a (w_addr_a[g]),
            .i_addr_b (w_addr_b[g]),
            .o_bus    (w_bus_out[g]),
            .o_data_a (w_data_a[g]),
            .o_data_b (w_data_b[g])
        );
    end

    assign w_last_m = {bit_perm(w_data_a[4], r_perm), bit_perm(w_data_b[4], r_perm)};

    // Output register: only decrypt items give a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_bus_out[4].valid && (w_bus_out[4].op == OP_DECRYPT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_item.plain_block  <= w_bus_out[4].cipher_block ^ w_last_m;
            r_out_item.counter_used <= w_bus_out[4].ctr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A decrypt item advances the counter low byte by one, with wrap.
    a_ctr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_item.op == OP_DECRYPT) |=> r_ctr_low == 8'($past(r_ctr_low) + 8'd1))
        else $error("counter low byte did not step");

    // A restart item clears the counter low byte.
    a_ctr_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_item.op == OP_RESTART) |=> r_ctr_low == 8'd0)
        else $error("counter low byte not cleared");

    // A held chain keeps its last cell unchanged.
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_bus_out[4]))
        else $error("chain moved while held");

    // Only a decrypt item leaving the last cell can raise a result.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !(w_bus_out[4].valid && w_bus_out[4].op == OP_DECRYPT)) |=> !r_out_valid)
        else $error("result without a decrypt item");

endmodule
